// ===== sv/rbmq_pkg.sv =====
// types and constants shared by the receive buffer match queue
package rbmq_pkg;

  localparam int QUEUE_DEPTH_DEF = 512;
  localparam logic [31:0] TAG_WILDCARD_RST = 32'hFFFF_FFFF;

  typedef enum logic [0:0] {
    CMD_NOTIFY = 1'b0,
    CMD_SEEK   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEEK,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] msg_tag;
    logic [31:0] msg_source;
    logic [31:0] msg_sequence;
    logic [31:0] msg_length;
    logic [15:0] buffer_slot;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic        found;
    logic [15:0] matched_slot;
    logic [31:0] matched_length;
  } rsp_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] source;
    logic [31:0] sequence_nr;
    logic [31:0] length;
    logic [15:0] slot;
  } entry_t;

endpackage

// ===== sv/rbmq_req_if.sv =====
// request channel carrying notify and seek items
interface rbmq_req_if import rbmq_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/rbmq_rsp_if.sv =====
// response channel carrying one result item per request
interface rbmq_rsp_if import rbmq_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/receive_buffer_match_queue_core.sv =====
// receive buffer match queue: circular entry store scanned by a one-entry-per-cycle sequencer
// notify: tail write when not full, then ST_DONE loads the result once the output is free
// seek: scans k entries (k up to the pending count, at most QUEUE_DEPTH), one store read
//   and one tail write per cycle through a single memory port pair
// the block takes no new item until the current result is in the output register
// reset: queue empty, head at zero, tag_wildcard all ones; the entry store is not cleared
module receive_buffer_match_queue_core import rbmq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  rbmq_req_if.sink        req_i,
  rbmq_rsp_if.source      rsp_o,
  input  logic            tag_wildcard_we_i,
  input  logic [31:0]     tag_wildcard_i
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW:0]   DEPTH_S = (CW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(QUEUE_DEPTH - 1);

  state_e        state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] issued_q, issued_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic          rd_vld_q, rd_vld_d;
  logic [31:0]   wildcard_q;
  req_t          key_q, key_d;
  rsp_t          res_q, res_d;
  rsp_t          out_q;
  logic          out_valid_q;
  logic          load_out;

  entry_t        mem_q [QUEUE_DEPTH];
  entry_t        rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;

  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic          hit;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST_A) ? '0 : p + 1'b1;
  endfunction

  assign tail_sum = (CW + 1)'(head_q) + (CW + 1)'(count_q);
  assign tail     = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);

  assign hit = (rdata_q.tag == key_q.msg_tag || rdata_q.tag == wildcard_q) &&
               rdata_q.source == key_q.msg_source &&
               rdata_q.sequence_nr == key_q.msg_sequence;

  assign req_i.ready   = (state_q == ST_IDLE);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    n_d       = n_q;
    issued_d  = issued_q;
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    rd_vld_d  = 1'b0;
    key_d     = key_q;
    res_d     = res_q;
    load_out  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = tail;
    mem_wdata = '{tag: req_i.payload.msg_tag, source: req_i.payload.msg_source,
                  sequence_nr: req_i.payload.msg_sequence,
                  length: req_i.payload.msg_length, slot: req_i.payload.buffer_slot};
    mem_re    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          key_d = req_i.payload;
          res_d = '0;
          if (req_i.payload.command == CMD_NOTIFY) begin
            if (count_q != DEPTH_C) begin
              mem_we         = 1'b1;
              count_d        = count_q + 1'b1;
              res_d.accepted = 1'b1;
            end
            state_d = ST_DONE;
          end else begin
            res_d.accepted = 1'b1;
            n_d            = count_q;
            issued_d       = '0;
            rd_ptr_d       = head_q;
            wr_ptr_d       = tail;
            state_d        = ST_SEEK;
          end
        end
      end
      ST_SEEK: begin
        if (issued_q != n_q) begin
          mem_re   = 1'b1;
          rd_ptr_d = ptr_inc(rd_ptr_q);
          issued_d = issued_q + 1'b1;
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q) begin
          head_d = ptr_inc(head_q);
          if (hit) begin
            res_d.found          = 1'b1;
            res_d.matched_slot   = rdata_q.slot;
            res_d.matched_length = rdata_q.length;
            count_d              = count_q - 1'b1;
            state_d              = ST_DONE;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = wr_ptr_q;
            mem_wdata = rdata_q;
            wr_ptr_d  = ptr_inc(wr_ptr_q);
          end
        end else if (issued_q == n_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      n_q         <= '0;
      issued_q    <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      rd_vld_q    <= 1'b0;
      wildcard_q  <= TAG_WILDCARD_RST;
      out_valid_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      count_q  <= count_d;
      n_q      <= n_d;
      issued_q <= issued_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      rd_vld_q <= rd_vld_d;
      if (tag_wildcard_we_i) begin
        wildcard_q <= tag_wildcard_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    res_q <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  // entry store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[rd_ptr_q];
    end
  end

endmodule
